>>> design/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg
// Shared constants and types of the frame receiver with ACK/NACK control.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam logic [7:0] START_BYTE     = 8'h5F;
  localparam logic [7:0] END_BYTE       = 8'hEF;
  localparam logic [7:0] MIN_LENGTH     = 8'd3;
  localparam logic [3:0] NACK_COUNT_MAX = 4'd15;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NACK_CODE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NACK_RETRIES = 2'd2;

  localparam logic [7:0] ACK_CODE_RST         = 8'd6;
  localparam logic [7:0] NACK_CODE_RST        = 8'd21;
  localparam logic [2:0] MAX_NACK_RETRIES_RST = 3'd3;

  typedef struct packed {
    logic [7:0] ack_code;
    logic [7:0] nack_code;
    logic [2:0] max_nack_retries;
  } frp_cfg_t;

  typedef struct packed {
    logic       frame_ok;
    logic [7:0] command;
    logic [7:0] first_data;
    logic [7:0] frame_length;
    logic       send_nack;
    logic       ack_seen;
    logic       retransmit;
    logic       length_error;
  } frp_result_t;

endpackage

>>> design/frp_rx_if.sv
// ----------------------------------------------------------------------------
// frp_rx_if
// Received byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface frp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> design/frp_res_if.sv
// ----------------------------------------------------------------------------
// frp_res_if
// Result channel: valid/ready handshake with the per-byte parse result.
// ----------------------------------------------------------------------------
interface frp_res_if;
  logic       valid;
  logic       ready;
  logic       frame_ok;
  logic [7:0] command;
  logic [7:0] first_data;
  logic [7:0] frame_length;
  logic       send_nack;
  logic       ack_seen;
  logic       retransmit;
  logic       length_error;

  modport source (
    output valid, output frame_ok, output command, output first_data,
    output frame_length, output send_nack, output ack_seen, output retransmit,
    output length_error, input ready
  );
  modport sink (
    input valid, input frame_ok, input command, input first_data,
    input frame_length, input send_nack, input ack_seen, input retransmit,
    input length_error, output ready
  );
endinterface

>>> design/frame_receiver_ack_nack_core.sv
// ----------------------------------------------------------------------------
// frame_receiver_ack_nack_core
// Parses received serial bytes into frames and drives ACK/NACK retry flags.
// ----------------------------------------------------------------------------
//  channel  direction  payload                          handshake
//  rx       in         rx_byte                          rx.valid / rx.ready
//  res      out        frame_ok .. length_error         res.valid / res.ready
//  cfg      in         cfg_idx_i, cfg_wdata_i           cfg_we_i
//
//  One byte is taken per cycle unless the result is stalled; its result is
//  registered and shows in the next cycle. A new byte is taken whenever the
//  single result register is empty or being drained in the same cycle.
//  Reset clears parse state, NACK counter, registers and the result valid.
//  A stalled result holds its payload and blocks further bytes.
// ----------------------------------------------------------------------------
module frame_receiver_ack_nack_core import frp_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  frp_rx_if.sink                rx,
  frp_res_if.source             res,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  frp_cfg_t    cfg_q;
  frp_result_t result;
  frp_result_t out_q;
  logic        out_valid_q;
  logic        take;

  assign rx.ready = !out_valid_q || res.ready;
  assign take     = rx.valid && rx.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_code         <= ACK_CODE_RST;
      cfg_q.nack_code        <= NACK_CODE_RST;
      cfg_q.max_nack_retries <= MAX_NACK_RETRIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACK_CODE:         cfg_q.ack_code         <= cfg_wdata_i;
        CFG_NACK_CODE:        cfg_q.nack_code        <= cfg_wdata_i;
        CFG_MAX_NACK_RETRIES: cfg_q.max_nack_retries <= cfg_wdata_i[2:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  frp_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .rx_byte_i(rx.rx_byte),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= result;
    end
  end

  assign res.valid        = out_valid_q;
  assign res.frame_ok     = out_q.frame_ok;
  assign res.command      = out_q.command;
  assign res.first_data   = out_q.first_data;
  assign res.frame_length = out_q.frame_length;
  assign res.send_nack    = out_q.send_nack;
  assign res.ack_seen     = out_q.ack_seen;
  assign res.retransmit   = out_q.retransmit;
  assign res.length_error = out_q.length_error;

  // every transfer in produces a result in the next cycle
  a_take_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) take |=> res.valid
  ) else $error("accepted byte did not produce a result");

  // at most one event flag per result
  a_flags_exclusive: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> $onehot0({res.frame_ok, res.send_nack, res.ack_seen,
                            res.retransmit, res.length_error})
  ) else $error("more than one event flag set");

  // a good frame always carries an in-range length
  a_frame_length_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.frame_ok) |->
      (res.frame_length >= MIN_LENGTH && res.frame_length <= 8'(BUFFER_BYTES))
  ) else $error("frame reported with out-of-range length");

  // payload fields stay zero when no frame completed
  a_payload_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res.valid && !res.frame_ok) |->
      (res.command == 8'd0 && res.first_data == 8'd0 && res.frame_length == 8'd0)
  ) else $error("frame payload set without frame_ok");

endmodule

>>> design/frp_parser.sv
// ----------------------------------------------------------------------------
// frp_parser
// Frame parse state and ACK/NACK counter; yields one result per byte taken.
// ----------------------------------------------------------------------------
module frp_parser import frp_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  rx_byte_i,
  input  frp_cfg_t    cfg_i,
  output frp_result_t result_o
);

  localparam int unsigned CW = $clog2(BUFFER_BYTES);
  localparam int unsigned LW = $clog2(BUFFER_BYTES + 1);
  localparam logic [7:0]  MAX_LENGTH = 8'(BUFFER_BYTES);

  logic [CW-1:0] byte_count_q, byte_count_d;
  logic [LW-1:0] frame_len_q, frame_len_d;
  logic [7:0]    cmd_hold_q, cmd_hold_d;
  logic [7:0]    data_hold_q, data_hold_d;
  logic [3:0]    nack_count_q, nack_count_d;
  logic [LW-1:0] pos_next;

  assign pos_next = LW'(byte_count_q) + LW'(1);

  always_comb begin
    byte_count_d = byte_count_q;
    frame_len_d  = frame_len_q;
    cmd_hold_d   = cmd_hold_q;
    data_hold_d  = data_hold_q;
    nack_count_d = nack_count_q;
    result_o     = '0;

    if (byte_count_q == '0) begin
      if (rx_byte_i == START_BYTE) begin
        byte_count_d = CW'(1);
      end else if (rx_byte_i == cfg_i.ack_code) begin
        nack_count_d      = '0;
        result_o.ack_seen = 1'b1;
      end else if (rx_byte_i == cfg_i.nack_code) begin
        // saturate the counter
        if (nack_count_q != NACK_COUNT_MAX) begin
          nack_count_d = nack_count_q + 4'd1;
        end
        result_o.retransmit = (nack_count_d <= {1'b0, cfg_i.max_nack_retries});
      end
    end else if (byte_count_q == CW'(1)) begin
      if (rx_byte_i < MIN_LENGTH || rx_byte_i > MAX_LENGTH) begin
        result_o.length_error = 1'b1;
        byte_count_d          = '0;
      end else begin
        frame_len_d  = LW'(rx_byte_i);
        byte_count_d = CW'(2);
      end
    end else begin
      if (byte_count_q == CW'(2)) begin
        cmd_hold_d = rx_byte_i;
      end else if (byte_count_q == CW'(3)) begin
        data_hold_d = rx_byte_i;
      end
      if (pos_next >= frame_len_q) begin
        // short frames report the freshly captured bytes
        if (rx_byte_i == END_BYTE) begin
          result_o.frame_ok     = 1'b1;
          result_o.command      = cmd_hold_d;
          result_o.first_data   = data_hold_d;
          result_o.frame_length = 8'(frame_len_q);
        end else begin
          result_o.send_nack = 1'b1;
        end
        byte_count_d = '0;
      end else begin
        byte_count_d = byte_count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      frame_len_q  <= '0;
      cmd_hold_q   <= '0;
      data_hold_q  <= '0;
      nack_count_q <= '0;
    end else if (take_i) begin
      byte_count_q <= byte_count_d;
      frame_len_q  <= frame_len_d;
      cmd_hold_q   <= cmd_hold_d;
      data_hold_q  <= data_hold_d;
      nack_count_q <= nack_count_d;
    end
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Bench for the frame receiver with ACK/NACK retry flags. Bytes are pushed
// through the rx channel. A parser model inside the bench keeps its own frame
// position, held bytes and NACK run, and works out the result of each byte.
// Each result is checked field by field as it drains. Both channels stall at
// random. The ACK/NACK codes and the retry limit change between batches.
// ----------------------------------------------------------------------------
module tb;
  import frp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUFFER_BYTES   = 16;
  localparam int unsigned BATCH_BYTES    = 230;
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned N_DIRECTED     = 24;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        known;
    frp_result_t result;
  } rx_row_t;

  localparam frp_result_t QUIET   = '0;
  localparam frp_result_t ACK_R   = '{ack_seen: 1'b1, default: '0};
  localparam frp_result_t RETX_R  = '{retransmit: 1'b1, default: '0};
  localparam frp_result_t LENE_R  = '{length_error: 1'b1, default: '0};
  localparam frp_result_t NACK_R  = '{send_nack: 1'b1, default: '0};
  localparam frp_result_t FRAME3  = '{frame_ok: 1'b1, command: 8'hEF, first_data: 8'h00,
                                      frame_length: 8'd3, default: '0};
  localparam frp_result_t FRAME4  = '{frame_ok: 1'b1, command: 8'hA5, first_data: 8'hEF,
                                      frame_length: 8'd4, default: '0};

  // Runs under the reset codes: ACK 0x06, NACK 0x15, three retries.
  localparam rx_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h00, 1'b1, QUIET},   // stray byte, ignored
    '{8'h06, 1'b1, ACK_R},
    '{8'h15, 1'b1, RETX_R},
    '{8'h15, 1'b1, RETX_R},
    '{8'h15, 1'b1, RETX_R},
    '{8'h15, 1'b1, QUIET},   // retries used up
    '{8'h06, 1'b1, ACK_R},
    '{8'h5F, 1'b0, QUIET},
    '{8'h02, 1'b1, LENE_R},  // length below minimum
    '{8'h5F, 1'b0, QUIET},
    '{8'h11, 1'b1, LENE_R},  // length above buffer
    '{8'h5F, 1'b0, QUIET},
    '{8'h03, 1'b0, QUIET},
    '{8'hEF, 1'b1, FRAME3},  // end byte doubles as command
    '{8'h5F, 1'b0, QUIET},
    '{8'h04, 1'b0, QUIET},
    '{8'hA5, 1'b0, QUIET},
    '{8'hEF, 1'b1, FRAME4},  // end byte doubles as first data
    '{8'h5F, 1'b0, QUIET},
    '{8'h05, 1'b0, QUIET},
    '{8'h12, 1'b0, QUIET},
    '{8'h34, 1'b0, QUIET},
    '{8'h00, 1'b1, NACK_R},  // wrong end byte
    '{8'hFF, 1'b1, QUIET}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  frp_rx_if  rx_ch ();
  frp_res_if res_ch ();

  frame_receiver_ack_nack_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx         (rx_ch),
    .res        (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Parser model state and its copy of the registers
  frp_cfg_t    rx_cfg    = '{ACK_CODE_RST, NACK_CODE_RST, MAX_NACK_RETRIES_RST};
  logic [4:0]  open_pos  = '0;
  logic [7:0]  open_len  = '0;
  logic [7:0]  held_cmd  = '0;
  logic [7:0]  held_data = '0;
  logic [3:0]  nack_run  = '0;

  rx_row_t     sent_rows_q[$];
  frp_result_t parse_results_q[$];
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  bit          steady_phase = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic frp_result_t parse_byte(input logic [7:0] b);
    frp_result_t r;
    int unsigned pos;
    r = '0;
    pos = 32'(open_pos);
    if (pos == 0) begin
      if (b == START_BYTE) begin
        open_pos = 5'd1;
      end else if (b == rx_cfg.ack_code) begin
        nack_run = '0;
        r.ack_seen = 1'b1;
      end else if (b == rx_cfg.nack_code) begin
        if (nack_run < NACK_COUNT_MAX) begin
          nack_run = nack_run + 4'd1;
        end
        if (nack_run <= 4'(rx_cfg.max_nack_retries)) begin
          r.retransmit = 1'b1;
        end
      end
    end else if (pos == 1) begin
      if (b < MIN_LENGTH || b > BUFFER_BYTES) begin
        r.length_error = 1'b1;
        open_pos = '0;
      end else begin
        open_len = b;
        open_pos = 5'd2;
      end
    end else begin
      if (pos == 2) begin
        held_cmd = b;
      end else if (pos == 3) begin
        held_data = b;
      end
      if (pos + 1 >= open_len) begin
        if (b == END_BYTE) begin
          r.frame_ok     = 1'b1;
          r.command      = held_cmd;
          r.first_data   = held_data;
          r.frame_length = open_len;
        end else begin
          r.send_nack = 1'b1;
        end
        open_pos = '0;
      end else begin
        open_pos = 5'(pos + 1);
      end
    end
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    if (steady_phase) begin
      return 0;
    end
    return $urandom_range(0, 3);
  endfunction

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %02h actual %02h", $time, fname, want, got);
    end
  endtask

  // Model each byte as it transfers; a typed row overrides the model's result
  always @(posedge clk_i) begin : rx_monitor
    rx_row_t     row;
    frp_result_t r;
    if (rx_ch.valid && rx_ch.ready) begin
      row = sent_rows_q.pop_front();
      r = parse_byte(rx_ch.rx_byte);
      parse_results_q.push_back(row.known ? row.result : r);
    end
  end

  always @(posedge clk_i) begin : res_checker
    frp_result_t want;
    if (res_ch.valid && res_ch.ready) begin
      if (parse_results_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, actual %p", $time,
                 {res_ch.frame_ok, res_ch.command, res_ch.first_data,
                  res_ch.frame_length, res_ch.send_nack, res_ch.ack_seen,
                  res_ch.retransmit, res_ch.length_error});
      end else begin
        want = parse_results_q.pop_front();
        check_field("frame_ok", 8'(want.frame_ok), 8'(res_ch.frame_ok));
        check_field("command", want.command, res_ch.command);
        check_field("first_data", want.first_data, res_ch.first_data);
        check_field("frame_length", want.frame_length, res_ch.frame_length);
        check_field("send_nack", 8'(want.send_nack), 8'(res_ch.send_nack));
        check_field("ack_seen", 8'(want.ack_seen), 8'(res_ch.ack_seen));
        check_field("retransmit", 8'(want.retransmit), 8'(res_ch.retransmit));
        check_field("length_error", 8'(want.length_error), 8'(res_ch.length_error));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each transfer
  initial begin : res_sink
    int unsigned stall;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // Valid stays high across back-to-back bytes; drop it only for a gap
  task automatic send_byte(input logic [7:0] b, input logic known, input frp_result_t r);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sent_rows_q.push_back('{b, known, r});
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk_i); while (!(rx_ch.valid && rx_ch.ready));
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_byte(b, 1'b0, QUIET);
  endtask

  // Hold the sender until every pending result has drained
  task automatic settle();
    rx_ch.valid <= 1'b0;
    do @(posedge clk_i); while (parse_results_q.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_codes(input logic [7:0] ack, input logic [7:0] nack,
                           input logic [2:0] retries);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ACK_CODE;
    cfg_wdata_i <= ack;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_NACK_CODE;
    cfg_wdata_i <= nack;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MAX_NACK_RETRIES;
    cfg_wdata_i <= CFG_DATA_W'(retries);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rx_cfg.ack_code         = ack;
    rx_cfg.nack_code        = nack;
    rx_cfg.max_nack_retries = retries;
  endtask

  // Mostly well-formed frames and code runs; stray bytes do not count
  task automatic feed_random(input int unsigned target);
    int unsigned fed;
    int unsigned pick;
    int unsigned len;
    int unsigned runs;
    fed = 0;
    while (fed < target) begin
      if ($urandom_range(0, 31) == 0) begin
        steady_phase = !steady_phase;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(3, BUFFER_BYTES)
                                          : $urandom_range(3, 6);
        send_plain(START_BYTE);
        send_plain(8'(len));
        for (int i = 2; i < len - 1; i++) begin
          send_plain(8'($urandom));
        end
        send_plain(($urandom_range(0, 5) == 0) ? 8'($urandom) : END_BYTE);
        fed += len;
      end else if (pick < 70) begin
        // long runs push the NACK count into saturation
        runs = $urandom_range(1, 18);
        repeat (runs) send_plain(rx_cfg.nack_code);
        if ($urandom_range(0, 1) == 1) begin
          send_plain(rx_cfg.ack_code);
          runs++;
        end
        fed += runs;
      end else if (pick < 80) begin
        send_plain(START_BYTE);
        send_plain(($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 2))
                                               : 8'($urandom_range(BUFFER_BYTES + 1, 255)));
        fed += 2;
      end else begin
        send_plain(8'($urandom));
      end
    end
    steady_phase = 1'b0;
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_ACK_CODE;
    cfg_wdata_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].result);
    end
    settle();

    feed_random(BATCH_BYTES);
    settle();
    set_codes(8'h00, 8'hFF, 3'd0);
    feed_random(BATCH_BYTES);
    settle();
    set_codes(8'hFF, 8'h00, 3'd7);
    feed_random(BATCH_BYTES);
    settle();
    // start byte shadows the ACK code
    set_codes(START_BYTE, 8'h06, 3'd7);
    feed_random(BATCH_BYTES);
    settle();
    // equal codes count as ACK only
    set_codes(8'h33, 8'h33, 3'd2);
    feed_random(BATCH_BYTES);
    settle();
    set_codes(8'h12, START_BYTE, 3'd5);
    feed_random(BATCH_BYTES);
    settle();
    set_codes(8'($urandom), 8'($urandom), 3'($urandom));
    feed_random(BATCH_BYTES);
    settle();
    repeat (4) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/frp_pkg.sv
design/frp_rx_if.sv
design/frp_res_if.sv
design/frp_parser.sv
design/frame_receiver_ack_nack_core.sv
sim/tb.sv
